@@ src/rec_pkg.sv @@
`timescale 1ns / 1ps

package rec_pkg;

  localparam int PROG_DEPTH  = 64;
  localparam int STACK_DEPTH = 128;

  localparam int PROG_AW  = $clog2(PROG_DEPTH);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);

  localparam int PC_W   = 7;
  localparam int OP_W   = 3;
  localparam int GEN_W  = 31;
  localparam int CNT_W  = 7;
  localparam int FCNT_W = 8;
  localparam int LEN_W  = 7;
  localparam int INSN_W = OP_W + 2 * PC_W;

  localparam logic [PC_W-1:0]  PC_INVALID = 7'd127;
  localparam logic [CNT_W-1:0] MAX_START  = 7'd64;

  localparam logic [OP_W-1:0] OP_CLASS   = 3'd0;
  localparam logic [OP_W-1:0] OP_SAVE    = 3'd1;
  localparam logic [OP_W-1:0] OP_EPSILON = 3'd2;
  localparam logic [OP_W-1:0] OP_ALT     = 3'd3;
  localparam logic [OP_W-1:0] OP_ACCEPT  = 3'd4;
  localparam logic [OP_W-1:0] OP_NOP     = 3'd5;
  localparam logic [OP_W-1:0] OP_LOOK    = 3'd6;
  localparam logic [OP_W-1:0] OP_MISC    = 3'd7;

  // successor pc outside the program maps to the invalid code
  function automatic logic [PC_W-1:0] encode_target(input logic [31:0] raw);
    if (raw < 32'(PROG_DEPTH)) begin
      return raw[PC_W-1:0];
    end
    return PC_INVALID;
  endfunction

  function automatic logic [OP_W-1:0] encode_op(input logic [31:0] raw);
    if (raw[31:OP_W] != '0) begin
      return OP_MISC;
    end
    return raw[OP_W-1:0];
  endfunction

endpackage

@@ src/rec_ram.sv @@
`timescale 1ns / 1ps

module rec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/regex_epsilon_closure.sv @@
`timescale 1ns / 1ps
// load word: written into the program memory in the cycle it is accepted, no result
// closure word: each visited pc passes a read state and an evaluate state, each stack pop
//   a pop state; a flush state then sends the last word, and the walk waits while out_ready is low
// one closure at a time; the single read port of each memory paces the walk
// reset (synchronous, rst_n low): visit mark valid bits and program_length cleared at
//   once, no clearing pass; program memory is undefined until loaded

module regex_epsilon_closure import rec_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_req_type,
  input  logic [5:0]        in_load_index,
  input  logic signed [31:0] in_load_opcode,
  input  logic signed [31:0] in_load_next,
  input  logic signed [31:0] in_load_alternate,
  input  logic signed [31:0] in_start_pc,
  input  logic [30:0]       in_generation,
  input  logic [6:0]        in_start_count,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        out_consumed_pc,
  output logic [6:0]        out_slot,
  output logic              out_found,
  output logic              out_start_valid,
  output logic [7:0]        out_final_count,
  output logic              out_last,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // walk sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;  // issue program and mark reads
  localparam logic [2:0] ST_EVAL  = 3'd2;  // read data back, decide
  localparam logic [2:0] ST_POP   = 3'd3;  // stack read data back
  localparam logic [2:0] ST_FLUSH = 3'd4;  // send the last word

  localparam logic REG_PROGRAM_LENGTH = 1'b0;

  logic [2:0]            state_r, state_nxt;
  logic [LEN_W-1:0]      len_r;
  logic [PROG_DEPTH-1:0] mark_vld_r, mark_vld_nxt;
  logic [SP_W-1:0]       sp_r, sp_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // payload registers
  logic [PC_W-1:0]       pc_r, pc_nxt;
  logic [GEN_W-1:0]      gen_r, gen_nxt;
  logic [CNT_W-1:0]      base_r, base_nxt;
  logic [PROG_AW-1:0]    pend_pc_r, pend_pc_nxt;
  logic [CNT_W-1:0]      pend_slot_r, pend_slot_nxt;
  logic [5:0]            out_pc_r, out_pc_nxt;
  logic [6:0]            out_slot_r, out_slot_nxt;
  logic                  out_found_r, out_found_nxt;
  logic                  out_sv_r, out_sv_nxt;
  logic [7:0]            out_fc_r, out_fc_nxt;
  logic                  out_last_r, out_last_nxt;

  // memory ports
  logic                  prog_we, prog_re;
  logic [INSN_W-1:0]     prog_wdata, prog_rdata;
  logic                  mark_we, mark_re;
  logic [GEN_W-1:0]      mark_rdata;
  logic                  stk_we, stk_re;
  logic [STACK_AW-1:0]   stk_waddr, stk_raddr;
  logic [PC_W-1:0]       stk_wdata, stk_rdata;

  logic [LEN_W-1:0]      len_eff;
  logic                  out_free;
  logic                  cfg_wr;
  logic [CNT_W-1:0]      in_base;
  logic [PROG_AW-1:0]    pc_addr;
  logic [OP_W-1:0]       ev_op;
  logic [PC_W-1:0]       ev_next, ev_alt;
  logic [GEN_W-1:0]      ev_mark;
  logic [FCNT_W-1:0]     fcount;

  // ---------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_wr && paddr[2] == REG_PROGRAM_LENGTH) begin
      len_r <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PROGRAM_LENGTH) ? {{(32-LEN_W){1'b0}}, len_r} : '0;

  // lengths past the table act as the full table
  assign len_eff = (len_r > LEN_W'(PROG_DEPTH)) ? LEN_W'(PROG_DEPTH) : len_r;

  // ---------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------
  assign pc_addr = pc_r[PROG_AW-1:0];

  assign prog_we    = in_valid & in_ready & ~in_req_type &
                      ({26'd0, in_load_index} < 32'(PROG_DEPTH));
  assign prog_wdata = {encode_op(in_load_opcode), encode_target(in_load_next),
                       encode_target(in_load_alternate)};

  rec_ram #(.WIDTH(INSN_W), .DEPTH(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (in_load_index[PROG_AW-1:0]),
    .wdata (prog_wdata),
    .re    (prog_re),
    .raddr (pc_addr),
    .rdata (prog_rdata)
  );

  rec_ram #(.WIDTH(GEN_W), .DEPTH(PROG_DEPTH)) u_mark (
    .clk   (clk),
    .we    (mark_we),
    .waddr (pc_addr),
    .wdata (gen_r),
    .re    (mark_re),
    .raddr (pc_addr),
    .rdata (mark_rdata)
  );

  rec_ram #(.WIDTH(PC_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // decoded instruction and effective mark (never written reads as zero)
  assign ev_op   = prog_rdata[INSN_W-1 -: OP_W];
  assign ev_next = prog_rdata[2*PC_W-1 -: PC_W];
  assign ev_alt  = prog_rdata[PC_W-1:0];
  assign ev_mark = mark_vld_r[pc_addr] ? mark_rdata : '0;

  assign out_free = ~out_valid_r | out_ready;
  assign in_ready = (state_r == ST_IDLE) & out_free;
  assign in_base  = (in_start_count > MAX_START) ? MAX_START : in_start_count;
  assign fcount   = {1'b0, base_r} + {1'b0, n_r};

  // ---------------------------------------------------------------
  // walk sequencer
  // ---------------------------------------------------------------
  always_comb begin
    logic do_pop;
    logic emit_busy;

    state_nxt     = state_r;
    mark_vld_nxt  = mark_vld_r;
    sp_nxt        = sp_r;
    n_nxt         = n_r;
    pend_vld_nxt  = pend_vld_r;
    pc_nxt        = pc_r;
    gen_nxt       = gen_r;
    base_nxt      = base_r;
    pend_pc_nxt   = pend_pc_r;
    pend_slot_nxt = pend_slot_r;

    out_valid_nxt = out_valid_r & ~out_ready;
    out_pc_nxt    = out_pc_r;
    out_slot_nxt  = out_slot_r;
    out_found_nxt = out_found_r;
    out_sv_nxt    = out_sv_r;
    out_fc_nxt    = out_fc_r;
    out_last_nxt  = out_last_r;

    prog_re   = 1'b0;
    mark_re   = 1'b0;
    mark_we   = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = sp_r[STACK_AW-1:0];
    stk_wdata = ev_alt;
    stk_re    = 1'b0;
    stk_raddr = STACK_AW'(sp_r - SP_W'(1));

    do_pop    = 1'b0;
    emit_busy = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready && in_req_type) begin
          if (in_start_pc >= {25'd0, len_eff}) begin
            // bad start pc: one word reporting failure
            out_valid_nxt = 1'b1;
            out_pc_nxt    = '0;
            out_slot_nxt  = in_base;
            out_found_nxt = 1'b0;
            out_sv_nxt    = 1'b0;
            out_fc_nxt    = {1'b0, in_base};
            out_last_nxt  = 1'b1;
          end else begin
            pc_nxt       = in_start_pc[PC_W-1:0];
            gen_nxt      = in_generation;
            base_nxt     = in_base;
            sp_nxt       = '0;
            n_nxt        = '0;
            pend_vld_nxt = 1'b0;
            state_nxt    = ST_READ;
          end
        end
      end

      ST_READ: begin
        if (pc_r >= len_eff) begin
          do_pop = 1'b1;
        end else begin
          prog_re   = 1'b1;
          mark_re   = 1'b1;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (ev_mark == gen_r) begin
          do_pop = 1'b1;
        end else begin
          priority if (ev_op == OP_ALT) begin
            // next is explored first, alternate is stacked; at sp 127 only alternate is walked
            if (sp_r < SP_W'(STACK_DEPTH - 1)) begin
              stk_we    = 1'b1;
              sp_nxt    = sp_r + SP_W'(1);
              pc_nxt    = ev_next;
              state_nxt = ST_READ;
            end else if (sp_r == SP_W'(STACK_DEPTH - 1)) begin
              pc_nxt    = ev_alt;
              state_nxt = ST_READ;
            end else begin
              do_pop = 1'b1;
            end
          end else if (ev_op == OP_NOP || ev_op == OP_SAVE || ev_op == OP_EPSILON) begin
            if (sp_r < SP_W'(STACK_DEPTH)) begin
              pc_nxt    = ev_next;
              state_nxt = ST_READ;
            end else begin
              do_pop = 1'b1;
            end
          end else begin
            // consuming pc: previous pending word goes out, this one is held (at most 64 per closure)
            if (n_r < CNT_W'(PROG_DEPTH)) begin
              if (pend_vld_r && !out_free) begin
                emit_busy = 1'b1;
              end else begin
                if (pend_vld_r) begin
                  out_valid_nxt = 1'b1;
                  out_pc_nxt    = 6'(pend_pc_r);
                  out_slot_nxt  = pend_slot_r;
                  out_found_nxt = 1'b1;
                  out_sv_nxt    = 1'b1;
                  out_fc_nxt    = '0;
                  out_last_nxt  = 1'b0;
                end
                pend_vld_nxt  = 1'b1;
                pend_pc_nxt   = pc_addr;
                pend_slot_nxt = base_r + n_r;
                n_nxt         = n_r + CNT_W'(1);
              end
            end
            if (!emit_busy) begin
              do_pop = 1'b1;
            end
          end
          if (!emit_busy) begin
            mark_we               = 1'b1;
            mark_vld_nxt[pc_addr] = 1'b1;
          end
        end
      end

      ST_POP: begin
        pc_nxt    = stk_rdata;
        state_nxt = ST_READ;
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sv_nxt    = 1'b1;
          out_fc_nxt    = fcount;
          out_last_nxt  = 1'b1;
          if (pend_vld_r) begin
            out_pc_nxt    = 6'(pend_pc_r);
            out_slot_nxt  = pend_slot_r;
            out_found_nxt = 1'b1;
          end else begin
            // empty closure
            out_pc_nxt    = '0;
            out_slot_nxt  = base_r;
            out_found_nxt = 1'b0;
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // pop the top of the stack, or finish when it is empty
    if (do_pop) begin
      if (sp_r == '0) begin
        state_nxt = ST_FLUSH;
      end else begin
        stk_re    = 1'b1;
        sp_nxt    = sp_r - SP_W'(1);
        state_nxt = ST_POP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mark_vld_r  <= '0;
      sp_r        <= '0;
      n_r         <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mark_vld_r  <= mark_vld_nxt;
      sp_r        <= sp_nxt;
      n_r         <= n_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc_r        <= pc_nxt;
    gen_r       <= gen_nxt;
    base_r      <= base_nxt;
    pend_pc_r   <= pend_pc_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_pc_r    <= out_pc_nxt;
    out_slot_r  <= out_slot_nxt;
    out_found_r <= out_found_nxt;
    out_sv_r    <= out_sv_nxt;
    out_fc_r    <= out_fc_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_consumed_pc = out_pc_r;
  assign out_slot        = out_slot_r;
  assign out_found       = out_found_r;
  assign out_start_valid = out_sv_r;
  assign out_final_count = out_fc_r;
  assign out_last        = out_last_r;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import rec_pkg::*;

  // request kinds on the input channel
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_CLOSURE = 1'b1;

  // register map: program_length is register 0, byte address 4*0
  localparam logic [2:0] ADDR_PROGRAM_LENGTH = 3'd0;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 40;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    logic        req_type;
    logic [5:0]  load_index;
    logic [31:0] load_opcode;
    logic [31:0] load_next;
    logic [31:0] load_alternate;
    logic [31:0] entry_pc;
    logic [30:0] generation;
    logic [6:0]  start_count;
  } request_t;

  // one entry of the caller's thread list, as the block reports it
  typedef struct {
    logic [5:0] pc;
    logic [6:0] slot;
    logic       found;
    logic       start_valid;
    logic [7:0] final_count;
    logic       last;
  } thread_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_req_type = 1'b0;
  logic [5:0]        in_load_index = '0;
  logic signed [31:0] in_load_opcode = '0;
  logic signed [31:0] in_load_next = '0;
  logic signed [31:0] in_load_alternate = '0;
  logic signed [31:0] in_start_pc = '0;
  logic [30:0]       in_generation = '0;
  logic [6:0]        in_start_count = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [5:0]        out_consumed_pc;
  logic [6:0]        out_slot;
  logic              out_found;
  logic              out_start_valid;
  logic [7:0]        out_final_count;
  logic              out_last;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  regex_epsilon_closure dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_load_index     (in_load_index),
    .in_load_opcode    (in_load_opcode),
    .in_load_next      (in_load_next),
    .in_load_alternate (in_load_alternate),
    .in_start_pc       (in_start_pc),
    .in_generation     (in_generation),
    .in_start_count    (in_start_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_consumed_pc   (out_consumed_pc),
    .out_slot          (out_slot),
    .out_found         (out_found),
    .out_start_valid   (out_start_valid),
    .out_final_count   (out_final_count),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: program table, visit marks and the length register
  // ---------------------------------------------------------------------------
  logic [2:0]  prog_op   [PROG_DEPTH];
  logic [6:0]  prog_next [PROG_DEPTH];
  logic [6:0]  prog_alt  [PROG_DEPTH];
  logic [30:0] visit_gen [PROG_DEPTH];
  logic [6:0]  prog_len_reg = '0;

  request_t      request_q[$];   // words waiting for the driver
  thread_entry_t thread_q[$];    // thread-list entries still to come out

  int err_cnt = 0;
  int n_loads = 0;
  int n_closures = 0;
  int n_entries = 0;
  int n_cfg = 0;
  int cycle_cnt = 0;

  initial begin
    for (int i = 0; i < PROG_DEPTH; i++) begin
      prog_op[i]   = '0;
      prog_next[i] = '0;
      prog_alt[i]  = '0;
      visit_gen[i] = '0;
    end
  end

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= PRINT_CAP)
      $display("tb: mismatch: %s", msg);
  endtask

  // successor pc as the table stores it: anything outside the program is invalid
  function automatic logic [6:0] succ_code(input logic [31:0] raw);
    return (raw < 32'(PROG_DEPTH)) ? raw[6:0] : 7'd127;
  endfunction

  // apply one accepted word: a load updates the table, a closure walks it and
  // queues the thread-list entries the block should produce
  function automatic void run_request(input request_t r);
    int            eff_len;
    int            base;
    int            sp;
    int            n;
    logic [6:0]    stk [STACK_DEPTH];
    logic [6:0]    pc;
    thread_entry_t ent;
    thread_entry_t walk_q[$];
    if (r.req_type == REQ_LOAD) begin
      prog_op[r.load_index]   = (r.load_opcode > 32'd7) ? OP_MISC : r.load_opcode[2:0];
      prog_next[r.load_index] = succ_code(r.load_next);
      prog_alt[r.load_index]  = succ_code(r.load_alternate);
      return;
    end
    eff_len = (prog_len_reg > 7'(PROG_DEPTH)) ? PROG_DEPTH : int'(prog_len_reg);
    base    = (r.start_count > MAX_START) ? int'(MAX_START) : int'(r.start_count);
    ent.pc          = '0;
    ent.slot        = 7'(base);
    ent.found       = 1'b0;
    ent.start_valid = 1'b1;
    ent.final_count = 8'(base);
    ent.last        = 1'b1;
    // start outside the program (negative values included, seen unsigned)
    if (r.entry_pc >= 32'(eff_len)) begin
      ent.start_valid = 1'b0;
      thread_q.push_back(ent);
      return;
    end
    sp = 0;
    n = 0;
    stk[sp] = r.entry_pc[6:0];
    sp = sp + 1;
    while (sp > 0) begin
      sp = sp - 1;
      pc = stk[sp];
      if (pc < 7'(eff_len) && visit_gen[pc[5:0]] != r.generation) begin
        visit_gen[pc[5:0]] = r.generation;
        case (prog_op[pc[5:0]])
          OP_ALT: begin
            // next is pushed last so it is explored first
            if (sp < STACK_DEPTH) begin
              stk[sp] = prog_alt[pc[5:0]];
              sp = sp + 1;
            end
            if (sp < STACK_DEPTH) begin
              stk[sp] = prog_next[pc[5:0]];
              sp = sp + 1;
            end
          end
          OP_NOP, OP_SAVE, OP_EPSILON: begin
            if (sp < STACK_DEPTH) begin
              stk[sp] = prog_next[pc[5:0]];
              sp = sp + 1;
            end
          end
          default: begin
            if (n < PROG_DEPTH) begin
              ent.pc          = pc[5:0];
              ent.slot        = 7'(base + n);
              ent.found       = 1'b1;
              ent.start_valid = 1'b1;
              ent.final_count = '0;
              ent.last        = 1'b0;
              walk_q.push_back(ent);
              n = n + 1;
            end
          end
        endcase
      end
    end
    if (n == 0) begin
      // empty closure: start was fine but nothing consuming was reached
      thread_q.push_back(ent);
      return;
    end
    walk_q[n-1].final_count = 8'(base + n);
    walk_q[n-1].last        = 1'b1;
    foreach (walk_q[i])
      thread_q.push_back(walk_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: bursts of words with random gaps, changes on the falling edge
  // ---------------------------------------------------------------------------
  request_t drv_req;
  bit       hold_in = 1'b0;
  logic     in_took = 1'b0;
  int       burst_left = 4;
  int       gap_left = 0;

  always @(posedge clk) begin
    in_took <= rst_n && in_valid && in_ready;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // word still waiting for ready: hold everything
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (hold_in || request_q.size() == 0) begin
      in_valid <= 1'b0;
    end else begin
      drv_req = request_q.pop_front();
      in_req_type       <= drv_req.req_type;
      in_load_index     <= drv_req.load_index;
      in_load_opcode    <= drv_req.load_opcode;
      in_load_next      <= drv_req.load_next;
      in_load_alternate <= drv_req.load_alternate;
      in_start_pc       <= drv_req.entry_pc;
      in_generation     <= drv_req.generation;
      in_start_count    <= drv_req.start_count;
      in_valid          <= 1'b1;
      if (burst_left <= 1) begin
        // about one burst in four is a long back-to-back stretch
        if ($urandom_range(3) == 0) begin
          burst_left <= $urandom_range(100, 40);
          gap_left   <= 0;
        end else begin
          burst_left <= $urandom_range(12, 1);
          gap_left   <= $urandom_range(6, 1);
        end
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: stall pattern switches between a few modes
  // ---------------------------------------------------------------------------
  int       rx_mode = 0;
  int       rx_mode_left = 100;
  bit [2:0] rx_pat = '0;

  always @(negedge clk) begin
    rx_pat <= rx_pat + 3'd1;
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(3);
      rx_mode_left <= $urandom_range(256, 64);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(9) < 7);
      2: out_ready <= (rx_pat[1:0] == 2'd0);
      default: out_ready <= (rx_pat == 3'd7);   // longest stall
    endcase
  end

  // ---------------------------------------------------------------------------
  // monitor: check results, then feed accepted words to the predictor
  // ---------------------------------------------------------------------------
  thread_entry_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_entries++;
        if (thread_q.size() == 0) begin
          report($sformatf("unexpected word pc=%0d slot=%0d last=%0b",
                           out_consumed_pc, out_slot, out_last));
        end else begin
          want = thread_q.pop_front();
          if (out_consumed_pc !== want.pc || out_slot !== want.slot ||
              out_found !== want.found || out_start_valid !== want.start_valid ||
              out_final_count !== want.final_count || out_last !== want.last)
            report($sformatf({"pc %0d/%0d slot %0d/%0d found %0b/%0b valid %0b/%0b",
                              " count %0d/%0d last %0b/%0b (got/want)"},
                             out_consumed_pc, want.pc, out_slot, want.slot,
                             out_found, want.found, out_start_valid, want.start_valid,
                             out_final_count, want.final_count, out_last, want.last));
        end
      end
      if (in_valid && in_ready) begin
        if (drv_req.req_type == REQ_LOAD)
          n_loads++;
        else
          n_closures++;
        run_request(drv_req);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  logic [30:0] gen_tag = 31'd10;
  logic [30:0] last_gen = '0;
  int          cur_span = 2;

  task automatic add_load(input logic [5:0] idx, input logic [31:0] op,
                          input logic [31:0] nxt, input logic [31:0] alt);
    request_t r;
    r.req_type       = REQ_LOAD;
    r.load_index     = idx;
    r.load_opcode    = op;
    r.load_next      = nxt;
    r.load_alternate = alt;
    // closure fields are don't-care on a load, keep them noisy
    r.entry_pc       = $urandom();
    r.generation     = 31'($urandom());
    r.start_count    = 7'($urandom());
    request_q.push_back(r);
  endtask

  task automatic add_closure(input logic [31:0] spc, input logic [30:0] gen,
                             input logic [6:0] cnt);
    request_t r;
    r.req_type       = REQ_CLOSURE;
    r.load_index     = 6'($urandom());
    r.load_opcode    = $urandom();
    r.load_next      = $urandom();
    r.load_alternate = $urandom();
    r.entry_pc       = spc;
    r.generation     = gen;
    r.start_count    = cnt;
    last_gen         = gen;
    request_q.push_back(r);
  endtask

  // successor mostly inside the current program, sometimes invalid
  function automatic logic [31:0] pick_target();
    int sel;
    sel = $urandom_range(99);
    if (sel < 82) return 32'($urandom_range(cur_span - 1));
    if (sel < 86) return 32'(cur_span);
    if (sel < 90) return 32'hFFFF_FFFF;
    if (sel < 93) return 32'(PROG_DEPTH);
    return $urandom();
  endfunction

  task automatic rand_load(input logic [5:0] idx);
    int          sel;
    logic [31:0] op;
    sel = $urandom_range(99);
    if (sel < 22) begin
      op = 32'(OP_ALT);
    end else if (sel < 44) begin
      case ($urandom_range(2))
        0: op = 32'(OP_SAVE);
        1: op = 32'(OP_EPSILON);
        default: op = 32'(OP_NOP);
      endcase
    end else if (sel < 82) begin
      case ($urandom_range(3))
        0: op = 32'(OP_CLASS);
        1: op = 32'(OP_ACCEPT);
        2: op = 32'(OP_LOOK);
        default: op = 32'(OP_MISC);
      endcase
    end else if (sel < 92) begin
      op = $urandom();                   // out-of-range raw opcode, mostly
    end else begin
      op = $urandom() | 32'h8000_0000;   // negative raw opcode
    end
    add_load(idx, op, pick_target(), pick_target());
  endtask

  task automatic rand_closure();
    int          sel;
    logic [31:0] spc;
    logic [30:0] gen;
    sel = $urandom_range(99);
    if (cur_span > 0 && prog_len_reg != 0 && sel < 85) begin
      spc = 32'($urandom_range(cur_span - 1));
    end else begin
      case ($urandom_range(5))
        0: spc = 32'(prog_len_reg);
        1: spc = 32'hFFFF_FFFF;
        2: spc = 32'h8000_0000;
        3: spc = 32'h7FFF_FFFF;
        4: spc = 32'(PROG_DEPTH);
        default: spc = $urandom();
      endcase
    end
    sel = $urandom_range(99);
    if (sel < 80) begin
      gen_tag = gen_tag + 31'd1;
      if (gen_tag == '0)
        gen_tag = 31'd1;
      gen = gen_tag;
    end else if (sel < 88) begin
      gen = last_gen;                    // same generation again: already visited
    end else if (sel < 92) begin
      gen = '0;
    end else begin
      gen = 31'($urandom());
    end
    if ($urandom_range(9) < 7)
      add_closure(spc, gen, 7'($urandom_range(64)));
    else
      add_closure(spc, gen, 7'($urandom_range(127)));
  endtask

  // block is idle: nothing queued, nothing in flight, nothing owed
  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || thread_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sender stops until every owed result has come out
  task automatic pause_for_results();
    while (request_q.size() != 0)
      @(posedge clk);
    hold_in = 1'b1;
    while (in_valid || thread_q.size() != 0)
      @(posedge clk);
    hold_in = 1'b0;
  endtask

  // write program_length over the cfg port, then read it back
  task automatic set_program_length(input logic [6:0] len);
    logic [31:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_PROGRAM_LENGTH;
    pwdata  <= 32'(len);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    prog_len_reg = len;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== 32'(len))
      report($sformatf("program_length read back %0d, wrote %0d", rd, len));
    cur_span = (len > 7'(PROG_DEPTH)) ? PROG_DEPTH : int'(len);
    if (cur_span < 2)
      cur_span = 2;
    n_cfg++;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  int phase_len [8] = '{64, 127, 1, 40, 0, 2, 64, 0};

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // length is zero after reset: any start pc is out of the program
    add_closure(32'd0, 31'd1, 7'd0);
    add_closure(32'hFFFF_FFFF, 31'd1, 7'd64);

    // small hand-built program touching every opcode and successor corner
    add_load(6'd0,  32'(OP_ALT),       32'd1, 32'd3);
    add_load(6'd1,  32'(OP_SAVE),      32'd2, 32'd64);
    add_load(6'd2,  32'(OP_CLASS),     32'd0, 32'd0);
    add_load(6'd3,  32'(OP_NOP),       32'd4, 32'hFFFF_FFFF);
    add_load(6'd4,  32'(OP_ALT),       32'd5, 32'd0);     // loops back to a visited pc
    add_load(6'd5,  32'(OP_EPSILON),   32'd6, 32'd63);
    add_load(6'd6,  32'(OP_ALT),       32'd7, 32'd14);    // alternate past the length
    add_load(6'd7,  32'(OP_ALT),       32'd8, 32'hFFFF_FFFB); // negative alternate
    add_load(6'd8,  32'(OP_LOOK),      32'd0, 32'd0);
    add_load(6'd9,  32'(OP_MISC),      32'd0, 32'd0);
    add_load(6'd10, 32'h8000_0000,     32'h8000_0000, 32'h7FFF_FFFF);
    add_load(6'd11, 32'(OP_ACCEPT),    32'd11, 32'd11);
    add_load(6'd63, 32'h7FFF_FFFF,     32'h7FFF_FFFF, 32'hFFFF_FFC0);
    wait_idle();

    set_program_length(7'd12);
    add_closure(32'd0, 31'd1, 7'd0);
    add_closure(32'd0, 31'd1, 7'd5);            // same generation: empty closure
    add_closure(32'd9, 31'd0, 7'd0);            // generation zero on fresh marks
    add_closure(32'd3, 31'd2, 7'd127);          // start count saturates
    add_closure(32'd9, 31'd2, 7'd64);
    add_closure(32'd10, 31'd3, 7'd65);
    pause_for_results();
    add_closure(32'd11, 31'h7FFF_FFFF, 7'd1);
    add_closure(32'd12, 31'd4, 7'd33);          // start exactly at the length
    add_closure(32'h8000_0000, 31'd5, 7'd0);
    add_closure(32'h7FFF_FFFF, 31'd6, 7'd7);
    add_closure(32'd6, 31'h2AAA_AAAA, 7'd0);
    add_closure(32'd1, 31'h5555_5555, 7'd100);
    wait_idle();

    // fill the rest of the table so any length is safe to walk
    cur_span = PROG_DEPTH;
    for (int i = 12; i < PROG_DEPTH - 1; i++)
      rand_load(6'(i));
    wait_idle();

    phase_len[7] = $urandom_range(63, 3);
    foreach (phase_len[ph]) begin
      set_program_length(7'(phase_len[ph]));
      for (int k = 0; k < 50; k++) begin
        if (k == 25 && (ph == 2 || $urandom_range(2) == 0))
          pause_for_results();
        if ($urandom_range(9) < 3)
          rand_load(6'($urandom_range(PROG_DEPTH - 1)));
        else
          rand_closure();
      end
      wait_idle();
    end

    if (thread_q.size() != 0)
      report($sformatf("%0d results never arrived", thread_q.size()));

    $display("tb: %0d loads and %0d closures sent, %0d thread-list words checked",
             n_loads, n_closures, n_entries);
    $display("tb: %0d program_length settings (0, 1, 64 and 127 among them), %0d errors",
             n_cfg, err_cnt);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/rec_pkg.sv
src/rec_ram.sv
src/regex_epsilon_closure.sv
verif/tb.sv
